@@ hw/rtl/pi3_pkg.sv @@
`default_nettype none

package pi3_pkg;

  localparam int DEF_PHASES      = 3;
  localparam int DEF_TAPS        = 48;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 15;
  localparam int COEF_LEN   = 48;
  localparam int COEF_AW    = $clog2(COEF_LEN);
  // wide enough for any tap index up to the largest supported tap count
  localparam int COEF_IDX_W = 7;

  // 48-tap low-pass prototype, gain of 3 folded in, Q1.15
  localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_LEN] = '{
    -16'sd56,    -16'sd117,   -16'sd67,    16'sd92,     16'sd232,    16'sd147,
    -16'sd203,   -16'sd508,   -16'sd313,   16'sd416,    16'sd1006,   16'sd605,
    -16'sd773,   -16'sd1841,  -16'sd1097,  16'sd1374,   16'sd3292,   16'sd1995,
    -16'sd2537,  -16'sd6405,  -16'sd4230,  16'sd6139,   16'sd20709,  16'sd31292,
    16'sd31292,  16'sd20709,  16'sd6139,   -16'sd4230,  -16'sd6405,  -16'sd2537,
    16'sd1995,   16'sd3292,   16'sd1374,   -16'sd1097,  -16'sd1841,  -16'sd773,
    16'sd605,    16'sd1006,   16'sd416,    -16'sd313,   -16'sd508,   -16'sd203,
    16'sd147,    16'sd232,    16'sd92,     -16'sd67,    -16'sd117,   -16'sd56
  };

  // indexes past the table read as zero
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (idx < COEF_IDX_W'(COEF_LEN)) begin
      c = COEF_TABLE[idx[COEF_AW-1:0]];
    end
    return c;
  endfunction

  typedef struct packed {
    logic load;    // shift a new sample in at the head
    logic rotate;  // circulate the line by one toward the head
  } hist_ctrl_t;

  typedef struct packed {
    logic issue;   // multiply the current head sample by the current coefficient
    logic first;   // this product starts a new sum
  } mac_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/pi3_hist.sv @@
`default_nettype none

module pi3_hist
  import pi3_pkg::*;
#(
  parameter int DEPTH       = DEF_TAPS / DEF_PHASES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hist_ctrl_t                    ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] din,
  output logic signed [SAMPLE_BITS-1:0]      head
);

  logic signed [SAMPLE_BITS-1:0] hist_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (ctrl.load) begin
      hist_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end else if (ctrl.rotate) begin
      // a full lap of DEPTH rotations leaves the line where it started
      for (int i = 0; i < DEPTH - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[DEPTH-1] <= hist_r[0];
    end
  end

  assign head = hist_r[0];

endmodule

`default_nettype wire

@@ hw/rtl/pi3_mac.sv @@
`default_nettype none

module pi3_mac
  import pi3_pkg::*;
#(
  parameter int DEPTH       = DEF_TAPS / DEF_PHASES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mac_ctrl_t                     ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic signed [COEF_W-1:0]      coef,
  output logic signed [SAMPLE_BITS-1:0]      result
);

  localparam int PW    = SAMPLE_BITS + COEF_W;
  localparam int ACC_W = PW + $clog2(DEPTH) + 1;
  localparam int SW    = ACC_W + 1;
  localparam int RW    = SW - COEF_FRAC;
  localparam logic signed [SW-1:0] HALF   = SW'(1) << (COEF_FRAC - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  logic signed [PW-1:0]    prod_r;
  logic                    pv_r;
  logic                    pfirst_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [SW-1:0]    sum_rnd;
  logic signed [RW-1:0]    rnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r     <= 1'b0;
      pfirst_r <= 1'b0;
    end else begin
      pv_r     <= ctrl.issue;
      pfirst_r <= ctrl.first;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod_r <= PW'(sample) * PW'(coef);
    end
  end

  assign prod_ext = ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (pv_r) begin
      acc_r <= pfirst_r ? prod_ext : acc_r + prod_ext;
    end
  end

  // add half an LSB, then drop the fraction: halves go toward plus infinity
  assign sum_rnd = SW'(acc_r) + HALF;
  assign rnd     = $signed(sum_rnd[SW-1:COEF_FRAC]);

  always_comb begin
    if (rnd > SAT_HI) begin
      result = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rnd < SAT_LO) begin
      result = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result = rnd[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/polyphase_interpolator_x3.sv @@
// Polyphase interpolate-by-PHASES FIR. Each transfer on the input channel
// shifts one signed sample into a history of TAPS/PHASES samples (all zero
// after reset) and produces PHASES results, one per branch, in branch order;
// out_last_of_run marks the final one. A single multiply-accumulate unit
// walks the taps one per cycle while the history line rotates past it. After
// the last tap of a branch, S_FLUSH drains the product register into the
// accumulator, and in S_OUT the rounded and saturated branch result goes to
// the output register. in_ready is high only between items. The output
// register decouples the result channel, so a stalled consumer only holds
// the sequencer once it wants to write the next branch result.
`default_nettype none

module polyphase_interpolator_x3
  import pi3_pkg::*;
#(
  parameter int PHASES      = DEF_PHASES,
  parameter int TAPS        = DEF_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  output logic [1:0]                         out_phase,
  output logic                               out_last_of_run
);

  localparam int DEPTH = TAPS / PHASES;
  localparam int TW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PHW   = $clog2(PHASES);
  localparam int IW    = $clog2(TAPS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_FLUSH,
    S_OUT
  } state_t;

  state_t                        state_r;
  logic [TW-1:0]                 tap_r;
  logic [PHW-1:0]                phase_r;
  logic [IW-1:0]                 coef_idx_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [1:0]                    out_phase_r;
  logic                          out_last_r;

  hist_ctrl_t                    hist_ctrl;
  mac_ctrl_t                     mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] head;
  logic signed [COEF_W-1:0]      coef;
  logic signed [SAMPLE_BITS-1:0] result;
  logic                          in_xfer;
  logic                          out_free;
  logic                          last_phase;

  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign last_phase = (phase_r == PHW'(PHASES - 1));

  assign hist_ctrl.load   = in_xfer;
  assign hist_ctrl.rotate = (state_r == S_MAC);
  assign mac_ctrl.issue   = (state_r == S_MAC);
  assign mac_ctrl.first   = (tap_r == '0);

  assign coef = coef_at(COEF_IDX_W'(coef_idx_r));

  pi3_hist #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (hist_ctrl),
    .din   (in_sample_in),
    .head  (head)
  );

  pi3_mac #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .sample (head),
    .coef   (coef),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_r       <= '0;
      phase_r     <= '0;
      coef_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_OUT the output register is handled by the branch write below
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r    <= S_MAC;
            tap_r      <= '0;
            phase_r    <= '0;
            coef_idx_r <= '0;
          end
        end
        S_MAC: begin
          tap_r      <= tap_r + TW'(1);
          coef_idx_r <= coef_idx_r + IW'(PHASES);
          if (tap_r == TW'(DEPTH - 1)) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register can take this branch
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= result;
            out_phase_r  <= 2'(phase_r);
            out_last_r   <= last_phase;
            if (last_phase) begin
              state_r <= S_IDLE;
            end else begin
              state_r    <= S_MAC;
              tap_r      <= '0;
              phase_r    <= phase_r + PHW'(1);
              coef_idx_r <= IW'(phase_r + PHW'(1));
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_phase       = out_phase_r;
  assign out_last_of_run = out_last_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_MAC) && (tap_r == '0) && !in_ready)
    else $error("sequencer did not start a run after an input transfer");

  a_last_on_final_branch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |-> (out_phase == 2'(PHASES - 1)))
    else $error("last_of_run on a branch other than the final one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ready) |=> (state_r == S_OUT))
    else $error("branch result left the sequencer while output was stalled");

endmodule

`default_nettype wire
